FILE: hw/rtl/potb_pkg.sv
// ----------------------------------------------------------------------------
// potb_pkg
// Shared types, codes and helpers for the periodic / one-shot timer bank.
// ----------------------------------------------------------------------------
package potb_pkg;

    localparam int NUM_TIMERS_DEFAULT = 16;

    localparam int TICK_W     = 32;
    localparam int CMD_W      = 3;
    localparam int KIND_W     = 3;
    localparam int IDX_W      = 4;
    localparam int TIU_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register select is paddr[2]
    localparam logic REG_TIMERS_IN_USE = 1'b0;

    localparam logic [TIU_W-1:0]  TIMERS_IN_USE_RESET = 5'd16;
    localparam logic [TICK_W-1:0] TICK_ALL_ONES       = 32'hFFFF_FFFF;

    localparam logic [CMD_W-1:0] CMD_SERVICE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INIT        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP        = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_PERIOD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMAINING   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NEXT_EXPIRY = 3'd6;

    localparam logic [KIND_W-1:0] KIND_FIRED        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACK          = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMAINING    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT_EXPIRY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SERVICE_DONE = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ONE_EX,
        ST_SVC_RD,
        ST_SVC_CALC,
        ST_SVC_UPD,
        ST_NXT_RD,
        ST_NXT_CMP,
        ST_FINAL
    } potb_state_t;

    typedef struct packed {
        logic load_item;
        logic one_ex;
        logic svc_calc;
        logic svc_upd;
        logic nxt_cmp;
        logic final_ex;
    } potb_cmd_t;

    typedef struct packed {
        logic is_service;
        logic is_next;
        logic scan_empty;
        logic scan_last;
        logic fire_due;
        logic out_free;
    } potb_status_t;

    // wrap-safe: a at or after b
    function automatic logic not_before(input logic [TICK_W-1:0] a,
                                        input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] d;
        d = a - b;
        return ~d[TICK_W-1];
    endfunction

endpackage

FILE: hw/rtl/potb_regs.sv
// ----------------------------------------------------------------------------
// potb_regs
// APB-style configuration register: timers_in_use.
// ----------------------------------------------------------------------------
module potb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [potb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [potb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [potb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [potb_pkg::TIU_W-1:0]         timers_in_use
);
    import potb_pkg::*;

    logic [TIU_W-1:0] tiu_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_TIMERS_IN_USE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiu_reg <= TIMERS_IN_USE_RESET;
        end else if (wr_en) begin
            tiu_reg <= pwdata[TIU_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TIMERS_IN_USE) begin
            prdata = {{(APB_DATA_W-TIU_W){1'b0}}, tiu_reg};
        end
    end

    assign timers_in_use = tiu_reg;

endmodule

FILE: hw/rtl/potb_ctrl.sv
// ----------------------------------------------------------------------------
// potb_ctrl
// Sequencer: decodes the held command and steps the datapath through
// single-timer commands and the service / next-expiry scans.
// ----------------------------------------------------------------------------
module potb_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  potb_pkg::potb_status_t  status,
    output potb_pkg::potb_cmd_t     cmd
);
    import potb_pkg::*;

    potb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if ((status.is_service || status.is_next) && status.scan_empty) begin
                    state_next = ST_FINAL;
                end else if (status.is_service) begin
                    state_next = ST_SVC_CALC;
                end else if (status.is_next) begin
                    state_next = ST_NXT_CMP;
                end else begin
                    state_next = ST_ONE_EX;
                end
            end
            ST_ONE_EX: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_SVC_RD:   state_next = ST_SVC_CALC;
            ST_SVC_CALC: state_next = ST_SVC_UPD;
            ST_SVC_UPD: begin
                if (!status.fire_due || status.out_free) begin
                    state_next = status.scan_last ? ST_FINAL : ST_SVC_RD;
                end
            end
            ST_NXT_RD:   state_next = ST_NXT_CMP;
            ST_NXT_CMP: begin
                state_next = status.scan_last ? ST_FINAL : ST_NXT_RD;
            end
            ST_FINAL: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd.load_item = (state_reg == ST_IDLE) && s_valid;
        cmd.one_ex    = (state_reg == ST_ONE_EX) && status.out_free;
        cmd.svc_calc  = (state_reg == ST_SVC_CALC);
        cmd.svc_upd   = (state_reg == ST_SVC_UPD) && (!status.fire_due || status.out_free);
        cmd.nxt_cmp   = (state_reg == ST_NXT_CMP);
        cmd.final_ex  = (state_reg == ST_FINAL) && status.out_free;
    end

endmodule

FILE: hw/rtl/potb_dp.sv
// ----------------------------------------------------------------------------
// potb_dp
// Datapath: timer stores, flags, scan counter, expiry arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module potb_dp #(
    parameter int NUM_TIMERS = potb_pkg::NUM_TIMERS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  potb_pkg::potb_cmd_t             cmd,
    output potb_pkg::potb_status_t          status,
    input  logic [potb_pkg::TIU_W-1:0]      timers_in_use,
    input  logic [potb_pkg::CMD_W-1:0]      s_command,
    input  logic [potb_pkg::IDX_W-1:0]      s_timer_index,
    input  logic [potb_pkg::TICK_W-1:0]     s_now_ms,
    input  logic [potb_pkg::TICK_W-1:0]     s_period_value,
    input  logic                            s_repeat_mode,
    input  logic                            s_has_handler,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [potb_pkg::KIND_W-1:0]     m_result_kind,
    output logic [potb_pkg::IDX_W-1:0]      m_fired_index,
    output logic [potb_pkg::TICK_W-1:0]     m_time_value,
    output logic                            m_none_pending,
    output logic                            m_last_result
);
    import potb_pkg::*;

    localparam int IW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    // held item
    logic [CMD_W-1:0]  item_cmd_reg;
    logic [IDX_W-1:0]  item_idx_reg;
    logic [TICK_W-1:0] item_now_reg;
    logic [TICK_W-1:0] item_per_reg;
    logic              item_rep_reg;
    logic              item_hnd_reg;

    logic [CNT_W-1:0]  scan_idx_reg;
    logic [CNT_W-1:0]  scan_next;
    logic [CNT_W-1:0]  scan_n;

    logic [NUM_TIMERS-1:0] active_reg;
    logic [NUM_TIMERS-1:0] periodic_reg;
    logic [NUM_TIMERS-1:0] handler_reg;

    logic [TICK_W-1:0] period_mem [NUM_TIMERS];
    logic [TICK_W-1:0] target_mem [NUM_TIMERS];
    logic [TICK_W-1:0] period_rd_reg;
    logic [TICK_W-1:0] target_rd_reg;

    logic              expired_reg;
    logic [TICK_W-1:0] t1_reg;
    logic [TICK_W-1:0] np_reg;

    logic              any_reg;
    logic              due_reg;
    logic              have_reg;
    logic [TICK_W-1:0] earliest_reg;

    logic              m_valid_reg;
    logic [KIND_W-1:0] m_kind_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [TICK_W-1:0] m_time_reg;
    logic              m_none_reg;
    logic              m_last_reg;

    logic              is_scan;
    logic              item_ok;
    logic [IW-1:0]     scan_addr;
    logic [IW-1:0]     item_addr;
    logic [IW-1:0]     rd_addr;
    logic              out_free;

    logic              period_we;
    logic [TICK_W-1:0] period_wd;
    logic              target_we;
    logic [IW-1:0]     target_wa;
    logic [TICK_W-1:0] target_wd;

    logic              out_load;
    logic [KIND_W-1:0] out_kind;
    logic [IDX_W-1:0]  out_idx;
    logic [TICK_W-1:0] out_time;
    logic              out_none;
    logic              out_last;

    logic [TICK_W-1:0] rem_diff;
    logic              fire_due;

    assign is_scan   = (item_cmd_reg == CMD_SERVICE) || (item_cmd_reg == CMD_NEXT_EXPIRY);
    assign item_ok   = (32'(item_idx_reg) < 32'(NUM_TIMERS));
    assign scan_addr = scan_idx_reg[IW-1:0];
    assign item_addr = IW'(item_idx_reg);
    assign rd_addr   = is_scan ? scan_addr : item_addr;
    assign scan_next = scan_idx_reg + CNT_W'(1);
    assign scan_n    = (32'(timers_in_use) > 32'(NUM_TIMERS)) ? CNT_W'(NUM_TIMERS)
                                                              : CNT_W'(timers_in_use);
    assign out_free  = !m_valid_reg || m_ready;
    assign fire_due  = expired_reg && handler_reg[scan_addr];
    assign rem_diff  = target_rd_reg - item_now_reg;

    assign status.is_service = (item_cmd_reg == CMD_SERVICE);
    assign status.is_next    = (item_cmd_reg == CMD_NEXT_EXPIRY);
    assign status.scan_empty = (scan_n == '0);
    assign status.scan_last  = (scan_next == scan_n);
    assign status.fire_due   = fire_due;
    assign status.out_free   = out_free;

    // item capture and scan counter
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_cmd_reg <= s_command;
            item_idx_reg <= s_timer_index;
            item_now_reg <= s_now_ms;
            item_per_reg <= s_period_value;
            item_rep_reg <= s_repeat_mode;
            item_hnd_reg <= s_has_handler;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
        end else if (cmd.load_item) begin
            scan_idx_reg <= '0;
        end else if (cmd.svc_upd || cmd.nxt_cmp) begin
            scan_idx_reg <= scan_next;
        end
    end

    // store write decode
    always_comb begin
        period_we = 1'b0;
        period_wd = item_per_reg;
        target_we = 1'b0;
        target_wa = item_addr;
        target_wd = '0;
        if (cmd.one_ex && item_ok) begin
            unique case (item_cmd_reg)
                CMD_INIT: begin
                    period_we = 1'b1;
                    target_we = 1'b1;
                    target_wd = '0;
                end
                CMD_START: begin
                    target_we = 1'b1;
                    target_wd = item_now_reg + period_rd_reg;
                end
                CMD_SET_PERIOD: begin
                    period_we = 1'b1;
                end
                default: begin
                    period_we = 1'b0;
                end
            endcase
        end else if (cmd.svc_upd && expired_reg && periodic_reg[scan_addr]) begin
            target_we = 1'b1;
            target_wa = scan_addr;
            target_wd = not_before(item_now_reg, t1_reg) ? np_reg : t1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        period_rd_reg <= period_mem[rd_addr];
        target_rd_reg <= target_mem[rd_addr];
        if (period_we) begin
            period_mem[item_addr] <= period_wd;
        end
        if (target_we) begin
            target_mem[target_wa] <= target_wd;
        end
    end

    // flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= '0;
            periodic_reg <= '0;
            handler_reg  <= '0;
        end else if (cmd.one_ex && item_ok) begin
            unique case (item_cmd_reg)
                CMD_INIT: begin
                    active_reg[item_addr]   <= 1'b0;
                    periodic_reg[item_addr] <= item_rep_reg;
                    handler_reg[item_addr]  <= item_hnd_reg;
                end
                CMD_START: active_reg[item_addr] <= 1'b1;
                CMD_STOP:  active_reg[item_addr] <= 1'b0;
                default:   active_reg <= active_reg;
            endcase
        end else if (cmd.svc_upd && expired_reg && !periodic_reg[scan_addr]) begin
            active_reg[scan_addr] <= 1'b0;
        end
    end

    // service arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.svc_calc) begin
            expired_reg <= active_reg[scan_addr] && not_before(item_now_reg, target_rd_reg);
            t1_reg      <= target_rd_reg + period_rd_reg;
            np_reg      <= item_now_reg + period_rd_reg;
        end
    end

    // earliest search
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg  <= 1'b0;
            due_reg  <= 1'b0;
            have_reg <= 1'b0;
        end else if (cmd.load_item) begin
            any_reg  <= 1'b0;
            due_reg  <= 1'b0;
            have_reg <= 1'b0;
        end else if (cmd.nxt_cmp && active_reg[scan_addr]) begin
            any_reg <= 1'b1;
            if (not_before(item_now_reg, target_rd_reg)) begin
                due_reg <= 1'b1;
            end else if (!have_reg || !not_before(target_rd_reg, earliest_reg)) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            earliest_reg <= TICK_ALL_ONES;
        end else if (cmd.nxt_cmp && active_reg[scan_addr]
                     && !not_before(item_now_reg, target_rd_reg)
                     && (!have_reg || !not_before(target_rd_reg, earliest_reg))) begin
            earliest_reg <= target_rd_reg;
        end
    end

    // result select
    always_comb begin
        out_load = 1'b0;
        out_kind = KIND_ACK;
        out_idx  = item_idx_reg;
        out_time = '0;
        out_none = 1'b0;
        out_last = 1'b1;
        if (cmd.one_ex) begin
            out_load = 1'b1;
            if (item_cmd_reg == CMD_REMAINING) begin
                out_kind = KIND_REMAINING;
                if (item_ok && active_reg[item_addr] && (rem_diff != '0)
                    && !rem_diff[TICK_W-1]) begin
                    out_time = rem_diff;
                end
            end
        end else if (cmd.svc_upd && fire_due) begin
            out_load = 1'b1;
            out_kind = KIND_FIRED;
            out_idx  = IDX_W'(scan_idx_reg);
            out_last = 1'b0;
        end else if (cmd.final_ex) begin
            out_load = 1'b1;
            out_idx  = '0;
            if (item_cmd_reg == CMD_SERVICE) begin
                out_kind = KIND_SERVICE_DONE;
            end else begin
                out_kind = KIND_NEXT_EXPIRY;
                out_time = due_reg ? item_now_reg : earliest_reg;
                out_none = !due_reg && !any_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg <= out_kind;
            m_idx_reg  <= out_idx;
            m_time_reg <= out_time;
            m_none_reg <= out_none;
            m_last_reg <= out_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_fired_index  = m_idx_reg;
    assign m_time_value   = m_time_reg;
    assign m_none_pending = m_none_reg;
    assign m_last_result  = m_last_reg;

endmodule

FILE: hw/rtl/periodic_oneshot_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank
// Bank of millisecond timers with service, start/stop and expiry queries.
//
// Init/start/stop/set period/remaining: decode, then execute. Service: read,
// compute, update per timer; next expiry: read, compare per timer. Both end
// in a final state, from decode if no timer is in use; a stalled result
// beat holds its step. Both scan one timer at a time through the single-port
// timer stores. Next beat accepted the cycle after the final result registers.
// Reset: flags and timers_in_use (16) reset at once; period and target stores
// are not reset, so there is no clearing pass.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank #(
    parameter int NUM_TIMERS = potb_pkg::NUM_TIMERS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [potb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [potb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [potb_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [potb_pkg::CMD_W-1:0]      s_command,
    input  logic [potb_pkg::IDX_W-1:0]      s_timer_index,
    input  logic [potb_pkg::TICK_W-1:0]     s_now_ms,
    input  logic [potb_pkg::TICK_W-1:0]     s_period_value,
    input  logic                            s_repeat_mode,
    input  logic                            s_has_handler,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [potb_pkg::KIND_W-1:0]     m_result_kind,
    output logic [potb_pkg::IDX_W-1:0]      m_fired_index,
    output logic [potb_pkg::TICK_W-1:0]     m_time_value,
    output logic                            m_none_pending,
    output logic                            m_last_result
);
    import potb_pkg::*;

    logic [TIU_W-1:0] timers_in_use;
    potb_cmd_t        cmd;
    potb_status_t     status;

    potb_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .timers_in_use (timers_in_use)
    );

    potb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    potb_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .timers_in_use  (timers_in_use),
        .s_command      (s_command),
        .s_timer_index  (s_timer_index),
        .s_now_ms       (s_now_ms),
        .s_period_value (s_period_value),
        .s_repeat_mode  (s_repeat_mode),
        .s_has_handler  (s_has_handler),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_fired_index  (m_fired_index),
        .m_time_value   (m_time_value),
        .m_none_pending (m_none_pending),
        .m_last_result  (m_last_result)
    );

endmodule

FILE: verif/timer_bank_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_bank_checker
// Watches the command, result and register ports of the timer bank, keeps
// its own copy of the timer state, predicts the result beats of every
// accepted command and compares them in order against the beats that leave.
// ----------------------------------------------------------------------------
module timer_bank_checker #(
    parameter int NUM_TIMERS = potb_pkg::NUM_TIMERS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [potb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [potb_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [potb_pkg::CMD_W-1:0]      s_command,
    input  logic [potb_pkg::IDX_W-1:0]      s_timer_index,
    input  logic [potb_pkg::TICK_W-1:0]     s_now_ms,
    input  logic [potb_pkg::TICK_W-1:0]     s_period_value,
    input  logic                            s_repeat_mode,
    input  logic                            s_has_handler,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [potb_pkg::KIND_W-1:0]     m_result_kind,
    input  logic [potb_pkg::IDX_W-1:0]      m_fired_index,
    input  logic [potb_pkg::TICK_W-1:0]     m_time_value,
    input  logic                            m_none_pending,
    input  logic                            m_last_result,
    output int unsigned                     mismatches,
    output int unsigned                     outstanding
);
    import potb_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  timer;
        logic [TICK_W-1:0] tick_val;
        logic              none_pending;
        logic              last;
    } timer_result_t;

    logic [TICK_W-1:0]     period_mem [NUM_TIMERS];
    logic [TICK_W-1:0]     target_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] armed;
    logic [NUM_TIMERS-1:0] periodic;
    logic [NUM_TIMERS-1:0] reports;
    logic [TIU_W-1:0]      scan_limit;
    timer_result_t         expected_results [$];
    timer_result_t         oldest;
    int                    clr_i;

    // wrap-safe: tick a at or after tick b
    function automatic logic tick_reached(input logic [TICK_W-1:0] a,
                                          input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] diff;
        diff = a - b;
        return !diff[TICK_W-1];
    endfunction

    task automatic push_result(input logic [KIND_W-1:0] kind,
                               input logic [IDX_W-1:0]  timer,
                               input logic [TICK_W-1:0] tick_val,
                               input logic              none_pending,
                               input logic              last);
        timer_result_t r;
        r.kind         = kind;
        r.timer        = timer;
        r.tick_val     = tick_val;
        r.none_pending = none_pending;
        r.last         = last;
        expected_results.push_back(r);
    endtask

    task automatic apply_timer_command(input logic [CMD_W-1:0]  cmd,
                                       input logic [IDX_W-1:0]  idx,
                                       input logic [TICK_W-1:0] now_t,
                                       input logic [TICK_W-1:0] per,
                                       input logic              rep,
                                       input logic              hnd);
        int                i;
        int                n;
        logic              in_bank;
        logic              due;
        logic              any_active;
        logic              found;
        logic [TICK_W-1:0] earliest;
        logic [TICK_W-1:0] diff;
        logic [TICK_W-1:0] rem;
        n          = (scan_limit > NUM_TIMERS) ? NUM_TIMERS : int'(scan_limit);
        in_bank    = (idx < NUM_TIMERS);
        due        = 1'b0;
        any_active = 1'b0;
        found      = 1'b0;
        earliest   = TICK_ALL_ONES;
        rem        = '0;
        case (cmd)
            CMD_SERVICE: begin
                for (i = 0; i < n; i++) begin
                    if (armed[i] && tick_reached(now_t, target_mem[i])) begin
                        if (periodic[i]) begin
                            target_mem[i] = target_mem[i] + period_mem[i];
                            // still behind after one period: snap forward
                            if (tick_reached(now_t, target_mem[i]))
                                target_mem[i] = now_t + period_mem[i];
                        end else begin
                            armed[i] = 1'b0;
                        end
                        if (reports[i])
                            push_result(KIND_FIRED, IDX_W'(i), '0, 1'b0, 1'b0);
                    end
                end
                push_result(KIND_SERVICE_DONE, '0, '0, 1'b0, 1'b1);
            end
            CMD_INIT: begin
                if (in_bank) begin
                    period_mem[idx] = per;
                    target_mem[idx] = '0;
                    reports[idx]    = hnd;
                    periodic[idx]   = rep;
                    armed[idx]      = 1'b0;
                end
            end
            CMD_START: begin
                if (in_bank) begin
                    target_mem[idx] = now_t + period_mem[idx];
                    armed[idx]      = 1'b1;
                end
            end
            CMD_STOP: begin
                if (in_bank)
                    armed[idx] = 1'b0;
            end
            CMD_SET_PERIOD: begin
                if (in_bank)
                    period_mem[idx] = per;
            end
            CMD_REMAINING: begin
                if (in_bank && armed[idx]) begin
                    diff = target_mem[idx] - now_t;
                    if (diff != '0 && !diff[TICK_W-1])
                        rem = diff;
                end
                push_result(KIND_REMAINING, idx, rem, 1'b0, 1'b1);
            end
            CMD_NEXT_EXPIRY: begin
                for (i = 0; i < n; i++) begin
                    if (armed[i]) begin
                        any_active = 1'b1;
                        if (tick_reached(now_t, target_mem[i])) begin
                            due = 1'b1;
                        end else if (!found || !tick_reached(target_mem[i], earliest)) begin
                            earliest = target_mem[i];
                            found    = 1'b1;
                        end
                    end
                end
                if (due)
                    push_result(KIND_NEXT_EXPIRY, '0, now_t, 1'b0, 1'b1);
                else
                    push_result(KIND_NEXT_EXPIRY, '0, earliest, !any_active, 1'b1);
            end
            default: begin
            end
        endcase
        if (cmd != CMD_SERVICE && cmd != CMD_REMAINING && cmd != CMD_NEXT_EXPIRY)
            push_result(KIND_ACK, idx, '0, 1'b0, 1'b1);
    endtask

    task automatic check_beat(input timer_result_t e);
        if (e.kind !== m_result_kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, m_result_kind);
            mismatches++;
        end
        if (e.timer !== m_fired_index) begin
            $error("fired_index: expected %0d, got %0d", e.timer, m_fired_index);
            mismatches++;
        end
        if (e.tick_val !== m_time_value) begin
            $error("time_value: expected 0x%08h, got 0x%08h", e.tick_val, m_time_value);
            mismatches++;
        end
        if (e.none_pending !== m_none_pending) begin
            $error("none_pending: expected %0b, got %0b", e.none_pending, m_none_pending);
            mismatches++;
        end
        if (e.last !== m_last_result) begin
            $error("last_result: expected %0b, got %0b", e.last, m_last_result);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (clr_i = 0; clr_i < NUM_TIMERS; clr_i++)
                target_mem[clr_i] = '0;
            armed      = '0;
            periodic   = '0;
            reports    = '0;
            scan_limit = TIMERS_IN_USE_RESET;
            mismatches = 0;
            expected_results.delete();
        end else begin
            // results leave before the beat accepted at this edge can add any
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation: kind %0d, index %0d",
                           m_result_kind, m_fired_index);
                    mismatches++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_beat(oldest);
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_TIMERS_IN_USE)
                scan_limit = pwdata[TIU_W-1:0];
            if (s_valid && s_ready)
                apply_timer_command(s_command, s_timer_index, s_now_ms, s_period_value,
                                    s_repeat_mode, s_has_handler);
        end
        outstanding = expected_results.size();
    end

endmodule

FILE: verif/tb_periodic_oneshot_timer_bank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_oneshot_timer_bank
// Drives commands into the timer bank: a directed pass over wrap-around
// ticks, zero and all-ones periods, targets of all ones and the reserved
// command code, then random command streams under several timers-in-use
// settings with idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module tb_periodic_oneshot_timer_bank;
    import potb_pkg::*;

    localparam int               NUM_TIMERS   = NUM_TIMERS_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command     = '0;
    logic [IDX_W-1:0]      s_timer_index = '0;
    logic [TICK_W-1:0]     s_now_ms      = '0;
    logic [TICK_W-1:0]     s_period_value = '0;
    logic                  s_repeat_mode = 1'b0;
    logic                  s_has_handler = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [KIND_W-1:0]     m_result_kind;
    logic [IDX_W-1:0]      m_fired_index;
    logic [TICK_W-1:0]     m_time_value;
    logic                  m_none_pending;
    logic                  m_last_result;

    int unsigned           mismatches;
    int unsigned           outstanding;

    int                    snd_idle_pct  = 22;
    int                    rcv_idle_pct  = 56;
    logic                  hold_armed    = 1'b0;
    logic                  hold_done     = 1'b0;
    int                    hold_left     = 0;
    logic [NUM_TIMERS-1:0] period_known  = '0;
    logic [TICK_W-1:0]     tick_now      = '0;

    periodic_oneshot_timer_bank #(
        .NUM_TIMERS(NUM_TIMERS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_timer_index (s_timer_index),
        .s_now_ms      (s_now_ms),
        .s_period_value(s_period_value),
        .s_repeat_mode (s_repeat_mode),
        .s_has_handler (s_has_handler),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_fired_index (m_fired_index),
        .m_time_value  (m_time_value),
        .m_none_pending(m_none_pending),
        .m_last_result (m_last_result)
    );

    timer_bank_checker #(
        .NUM_TIMERS(NUM_TIMERS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_timer_index (s_timer_index),
        .s_now_ms      (s_now_ms),
        .s_period_value(s_period_value),
        .s_repeat_mode (s_repeat_mode),
        .s_has_handler (s_has_handler),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_fired_index (m_fired_index),
        .m_time_value  (m_time_value),
        .m_none_pending(m_none_pending),
        .m_last_result (m_last_result),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always begin
        #4 aclk = ~aclk;
    end

    // result side: random back-pressure, or one long hold once armed
    always @(negedge aclk) begin
        if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 250;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_command(input logic [CMD_W-1:0]  cmd,
                                input logic [IDX_W-1:0]  idx,
                                input logic [TICK_W-1:0] now_t,
                                input logic [TICK_W-1:0] per,
                                input logic              rep,
                                input logic              hnd);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_timer_index  <= idx;
        s_now_ms       <= now_t;
        s_period_value <= per;
        s_repeat_mode  <= rep;
        s_has_handler  <= hnd;
        if ((cmd == CMD_INIT || cmd == CMD_SET_PERIOD) && idx < NUM_TIMERS)
            period_known[idx] = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_timers_in_use(input logic [TIU_W-1:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TIMERS_IN_USE, 2'b00};
        pwdata  <= APB_DATA_W'(count);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    function automatic logic [TICK_W-1:0] pick_period();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return '0;
        if (pick < 16)
            return $urandom;
        return $urandom_range(1, 60);
    endfunction

    task automatic send_random_command();
        int unsigned      pick;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            tick_now = tick_now + $urandom;
        else if (pick < 6)
            tick_now = TICK_ALL_ONES - $urandom_range(0, 40);
        else
            tick_now = tick_now + $urandom_range(0, 25);
        idx  = IDX_W'($urandom_range(0, NUM_TIMERS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            cmd = CMD_INIT;
        else if (pick < 30)
            cmd = period_known[idx] ? CMD_START : CMD_INIT; // never start on an unset period
        else if (pick < 36)
            cmd = CMD_STOP;
        else if (pick < 42)
            cmd = CMD_SET_PERIOD;
        else if (pick < 52)
            cmd = CMD_REMAINING;
        else if (pick < 62)
            cmd = CMD_NEXT_EXPIRY;
        else if (pick < 64)
            cmd = CMD_RESERVED;
        else
            cmd = CMD_SERVICE;
        send_command(cmd, idx, tick_now, pick_period(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_timers_in_use(5'd16);
        send_command(CMD_NEXT_EXPIRY, 4'd0,  32'h0000_0000, '0, 1'b0, 1'b0);
        send_command(CMD_INIT,        4'd0,  32'h0000_0000, 32'd10, 1'b1, 1'b1);
        send_command(CMD_INIT,        4'd15, 32'h0000_0000, TICK_ALL_ONES, 1'b0, 1'b1);
        send_command(CMD_INIT,        4'd1,  32'h0000_0000, 32'd0, 1'b1, 1'b1);
        send_command(CMD_INIT,        4'd2,  32'h0000_0000, 32'd5, 1'b0, 1'b0);
        send_command(CMD_START,       4'd0,  32'hFFFF_FFFA, '0, 1'b0, 1'b0);
        send_command(CMD_START,       4'd1,  32'hFFFF_FFFA, '0, 1'b0, 1'b0);
        send_command(CMD_START,       4'd2,  32'hFFFF_FFFA, '0, 1'b0, 1'b0);
        send_command(CMD_START,       4'd15, 32'h0000_0000, '0, 1'b0, 1'b0);
        send_command(CMD_REMAINING,   4'd0,  32'hFFFF_FFFC, '0, 1'b0, 1'b0);
        send_command(CMD_REMAINING,   4'd3,  32'h0000_0000, '0, 1'b0, 1'b0);
        send_command(CMD_NEXT_EXPIRY, 4'd0,  32'hFFFF_FFFB, '0, 1'b0, 1'b0);
        send_command(CMD_STOP,        4'd1,  32'hFFFF_FFFB, '0, 1'b0, 1'b0);
        send_command(CMD_NEXT_EXPIRY, 4'd0,  32'hFFFF_FFFB, '0, 1'b0, 1'b0);
        send_command(CMD_SERVICE,     4'd0,  TICK_ALL_ONES, '0, 1'b0, 1'b0);
        send_command(CMD_SERVICE,     4'd0,  32'd20, '0, 1'b0, 1'b0);
        send_command(CMD_SERVICE,     4'd0,  32'd31, '0, 1'b0, 1'b0);
        send_command(CMD_SET_PERIOD,  4'd0,  32'd31, 32'd3, 1'b1, 1'b1);
        send_command(CMD_REMAINING,   4'd0,  32'd40, '0, 1'b0, 1'b0);
        send_command(CMD_RESERVED,    4'd9,  32'd40, TICK_ALL_ONES, 1'b1, 1'b1);
        send_command(CMD_START,       4'd1,  32'd100, '0, 1'b0, 1'b0);
        send_command(CMD_SERVICE,     4'd0,  32'd100, '0, 1'b0, 1'b0);
        send_command(CMD_SERVICE,     4'd0,  32'd100, '0, 1'b0, 1'b0);
        send_command(CMD_REMAINING,   4'd1,  32'd101, '0, 1'b0, 1'b0);
        tick_now = 32'd120;

        drain_results(8);
        write_timers_in_use(5'd0);
        repeat (8) send_random_command();

        drain_results(8);
        write_timers_in_use(5'd16);
        repeat (35) send_random_command();

        drain_results(8);
        snd_idle_pct = 56;
        rcv_idle_pct = 22;
        write_timers_in_use(5'd31);
        repeat (35) send_random_command();

        drain_results(8);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_timers_in_use(5'd9);
        repeat (10) send_random_command();
        hold_armed = 1'b1;
        repeat (20) send_random_command();

        drain_results(60);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
